/* design/mcr_pkg.sv */
// Package of the midpoint circle rasterizer: command and mode codes, the step
// request that travels from front end to back end, and the pixel pattern table.
// It depends on nothing and is imported by every design module of the block; the port checker does not import it.
package mcr_pkg;

  localparam int unsigned COORD_W  = 10;
  localparam int unsigned RADIUS_W = 9;
  localparam int unsigned PIXEL_W  = 12;
  localparam int unsigned DEC_W    = 12;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FULL  = 2'd0,
    MODE_UPPER = 2'd1,
    MODE_LOWER = 2'd2
  } mode_e;

  // One step request: everything the back end needs to emit its pixels.
  typedef struct packed {
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [RADIUS_W-1:0] x;
    logic [RADIUS_W-1:0] y;
    mode_e               mode;
    logic                finished;
  } step_t;

  // How one pixel is built from the octant offsets.
  typedef struct packed {
    logic col_use_y;
    logic col_neg;
    logic row_use_y;
    logic row_neg;
  } pat_t;

  function automatic pat_t mcr_pattern(mode_e mode, logic [2:0] idx);
    pat_t p;
    p = '0;
    unique case (mode)
      MODE_UPPER: begin
        unique case (idx[1:0])
          2'd0: p = '{col_use_y: 1'b0, col_neg: 1'b0, row_use_y: 1'b1, row_neg: 1'b1};
          2'd1: p = '{col_use_y: 1'b1, col_neg: 1'b0, row_use_y: 1'b0, row_neg: 1'b1};
          2'd2: p = '{col_use_y: 1'b0, col_neg: 1'b1, row_use_y: 1'b1, row_neg: 1'b1};
          default: p = '{col_use_y: 1'b1, col_neg: 1'b1, row_use_y: 1'b0, row_neg: 1'b1};
        endcase
      end
      MODE_LOWER: begin
        unique case (idx[1:0])
          2'd0: p = '{col_use_y: 1'b0, col_neg: 1'b1, row_use_y: 1'b1, row_neg: 1'b0};
          2'd1: p = '{col_use_y: 1'b1, col_neg: 1'b1, row_use_y: 1'b0, row_neg: 1'b0};
          2'd2: p = '{col_use_y: 1'b0, col_neg: 1'b0, row_use_y: 1'b1, row_neg: 1'b0};
          default: p = '{col_use_y: 1'b1, col_neg: 1'b0, row_use_y: 1'b0, row_neg: 1'b0};
        endcase
      end
      default: begin
        unique case (idx)
          3'd0: p = '{col_use_y: 1'b0, col_neg: 1'b0, row_use_y: 1'b1, row_neg: 1'b0};
          3'd1: p = '{col_use_y: 1'b0, col_neg: 1'b0, row_use_y: 1'b1, row_neg: 1'b1};
          3'd2: p = '{col_use_y: 1'b0, col_neg: 1'b1, row_use_y: 1'b1, row_neg: 1'b0};
          3'd3: p = '{col_use_y: 1'b0, col_neg: 1'b1, row_use_y: 1'b1, row_neg: 1'b1};
          3'd4: p = '{col_use_y: 1'b1, col_neg: 1'b0, row_use_y: 1'b0, row_neg: 1'b0};
          3'd5: p = '{col_use_y: 1'b1, col_neg: 1'b0, row_use_y: 1'b0, row_neg: 1'b1};
          3'd6: p = '{col_use_y: 1'b1, col_neg: 1'b1, row_use_y: 1'b0, row_neg: 1'b0};
          default: p = '{col_use_y: 1'b1, col_neg: 1'b1, row_use_y: 1'b0, row_neg: 1'b1};
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

/* design/mcr_front.sv */
// Front end of the circle rasterizer: accepts requests, keeps the octant
// position and decision value, and queues one step request per step command
// while a circle runs. Depends on mcr_pkg.
module mcr_front
  import mcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cmd_e                cmd_i,
  input  logic [COORD_W-1:0]  cx_i,
  input  logic [COORD_W-1:0]  cy_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic [1:0]          mode_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output step_t               push_data_o
);

  logic [RADIUS_W-1:0]    x_q, x_d;
  logic [RADIUS_W-1:0]    y_q, y_d;
  logic signed [DEC_W-1:0] p_q, p_d;
  logic                   busy_q, busy_d;
  mode_e                  mode_q, mode_d;
  logic [COORD_W-1:0]     cx_q, cx_d;
  logic [COORD_W-1:0]     cy_q, cy_d;

  logic                   accept;
  logic [RADIUS_W:0]      x_inc;
  logic                   dec_neg;
  logic signed [RADIUS_W+1:0] y_dec;
  logic signed [DEC_W+1:0]    p_next;
  logic                   done;
  mode_e                  mode_new;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (cmd_i == CMD_STEP) && busy_q;

  always_comb begin
    x_inc   = {1'b0, x_q} + (RADIUS_W+1)'(1);
    dec_neg = p_q[DEC_W-1];
    y_dec   = $signed({2'b00, y_q}) - (dec_neg ? (RADIUS_W+2)'(0) : (RADIUS_W+2)'(1));
    p_next  = $signed({{2{p_q[DEC_W-1]}}, p_q})
            + $signed({3'b000, x_inc, 1'b1})
            - (dec_neg ? (DEC_W+2)'(0) : $signed({{2{y_dec[RADIUS_W+1]}}, y_dec, 1'b0}));
    done    = $signed({1'b0, x_inc}) > y_dec;
  end

  always_comb begin
    priority if (mode_i == MODE_UPPER) begin
      mode_new = MODE_UPPER;
    end else if (mode_i == MODE_LOWER) begin
      mode_new = MODE_LOWER;
    end else begin
      mode_new = MODE_FULL;
    end
  end

  always_comb begin
    push_data_o.cx       = cx_q;
    push_data_o.cy       = cy_q;
    push_data_o.x        = x_q;
    push_data_o.y        = y_q;
    push_data_o.mode     = mode_q;
    push_data_o.finished = done;
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    p_d    = p_q;
    busy_d = busy_q;
    mode_d = mode_q;
    cx_d   = cx_q;
    cy_d   = cy_q;
    if (accept && (cmd_i == CMD_START)) begin
      cx_d   = cx_i;
      cy_d   = cy_i;
      x_d    = '0;
      y_d    = radius_i;
      p_d    = DEC_W'(1) - $signed({3'b000, radius_i});
      mode_d = mode_new;
      busy_d = 1'b1;
    end else if (push_o) begin
      if (done) begin
        busy_d = 1'b0;
        x_d    = '0;
        y_d    = '0;
        p_d    = '0;
      end else begin
        x_d = x_inc[RADIUS_W-1:0];
        y_d = y_dec[RADIUS_W-1:0];
        p_d = p_next[DEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      p_q    <= '0;
      busy_q <= 1'b0;
      mode_q <= MODE_FULL;
      cx_q   <= '0;
      cy_q   <= '0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      p_q    <= p_d;
      busy_q <= busy_d;
      mode_q <= mode_d;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
    end
  end

endmodule

/* design/mcr_queue.sv */
// Short queue of step requests between the front end and the back end of the
// circle rasterizer, held in flip-flops. Depends on mcr_pkg.
module mcr_queue
  import mcr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output step_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  step_t             mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* design/mcr_back.sv */
// Back end of the circle rasterizer: turns the step request at the head of the
// queue into its symmetric pixels, one per cycle while the output is not stalled,
// through an output register. Depends on mcr_pkg.
module mcr_back
  import mcr_pkg::*;
#(
  parameter int unsigned FRAME_SIZE = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  step_t              head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIXEL_W-1:0] pixel_x_o,
  output logic [PIXEL_W-1:0] pixel_y_o,
  output logic               in_frame_o,
  output logic               last_o,
  output logic               finished_o
);

  localparam logic signed [PIXEL_W-1:0] FrameLim = PIXEL_W'(FRAME_SIZE);

  logic [2:0]                idx_q, idx_d;
  logic                      valid_q;
  logic [PIXEL_W-1:0]        px_q, py_q;
  logic                      in_frame_q, last_q, finished_q;

  logic                      load;
  logic                      gen;
  logic                      last_pix;
  pat_t                      pat;
  logic [RADIUS_W-1:0]       col_mag, row_mag;
  logic signed [PIXEL_W-1:0] col, row;
  logic                      in_bounds;

  assign load     = !valid_q || out_ready_i;
  assign gen      = load && head_valid_i;
  assign last_pix = (head_i.mode == MODE_FULL) ? (idx_q == 3'd7) : (idx_q == 3'd3);
  assign pop_o    = gen && last_pix;

  always_comb begin
    pat       = mcr_pattern(head_i.mode, idx_q);
    col_mag   = pat.col_use_y ? head_i.y : head_i.x;
    row_mag   = pat.row_use_y ? head_i.y : head_i.x;
    col       = pat.col_neg ? $signed({2'b00, head_i.cx}) - $signed({3'b000, col_mag})
                            : $signed({2'b00, head_i.cx}) + $signed({3'b000, col_mag});
    row       = pat.row_neg ? $signed({2'b00, head_i.cy}) - $signed({3'b000, row_mag})
                            : $signed({2'b00, head_i.cy}) + $signed({3'b000, row_mag});
    in_bounds = !col[PIXEL_W-1] && (col < FrameLim) && !row[PIXEL_W-1] && (row < FrameLim);
    idx_d     = idx_q;
    if (gen) begin
      idx_d = last_pix ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen) begin
      px_q       <= col;
      py_q       <= row;
      in_frame_q <= in_bounds;
      last_q     <= last_pix;
      finished_q <= head_i.finished;
    end
  end

  assign out_valid_o = valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign in_frame_o  = in_frame_q;
  assign last_o      = last_q;
  assign finished_o  = finished_q;

endmodule

/* design/midpoint_circle_rasterizer_unit.sv */
// Midpoint circle rasterizer. A start request (tuser low) loads center, radius
// and drawing mode and produces no output; each step request (tuser high)
// produces eight pixels for a full circle or four for a half circle, one per
// cycle while the output is not stalled, with tlast on the last pixel of the
// step and tuser set on every pixel of the final step. The front end takes one
// request per cycle while the queue is not full and parks step requests in a
// four-entry queue, so input runs ahead of output; the pixel generator in the
// back end sets the sustained rate. Steps while no circle runs are dropped.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
#(
  parameter int unsigned FRAME_SIZE = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // center_x [9:0], center_y [19:10], radius [28:20], draw_mode [30:29], zero [31]
  input  logic [31:0] s_axis_tdata_i,
  // command [0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_x [11:0], pixel_y [23:12], in_frame [24], zero [31:25]
  output logic [31:0] m_axis_tdata_o,
  // last_of_step
  output logic        m_axis_tlast_o,
  // finished [0]
  output logic        m_axis_tuser_o
);

  logic               queue_full;
  logic               push;
  step_t              push_data;
  logic               pop;
  logic               head_valid;
  step_t              head;
  logic [PIXEL_W-1:0] pixel_x, pixel_y;
  logic               in_frame;
  cmd_e               cmd;

  assign cmd = cmd_e'(s_axis_tuser_i);

  mcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .cmd_i        (cmd),
    .cx_i         (s_axis_tdata_i[9:0]),
    .cy_i         (s_axis_tdata_i[19:10]),
    .radius_i     (s_axis_tdata_i[28:20]),
    .mode_i       (s_axis_tdata_i[30:29]),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  mcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mcr_back #(
    .FRAME_SIZE (FRAME_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .in_frame_o   (in_frame),
    .last_o       (m_axis_tlast_o),
    .finished_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {7'b0000000, in_frame, pixel_y, pixel_x};

endmodule

/* design/mcr_checker.sv */
// Port checker of the circle rasterizer with its bind to the top level.
// Depends only on the ports of midpoint_circle_rasterizer_unit.
module mcr_checker #(
  parameter int unsigned FRAME_SIZE = 512
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  localparam logic signed [11:0] FrameLim = 12'(FRAME_SIZE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled pixel changed");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("pixel shown right after reset");

  a_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[24] |->
      !m_axis_tdata_o[11] && !m_axis_tdata_o[23]
      && ($signed(m_axis_tdata_o[11:0]) < FrameLim)
      && ($signed(m_axis_tdata_o[23:12]) < FrameLim))
    else $error("in-frame flag on a pixel outside the frame");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[11:0]) >= -12'sd512)
      && ($signed(m_axis_tdata_o[23:12]) >= -12'sd512)
      && (m_axis_tdata_o[31:25] == 7'd0))
    else $error("pixel coordinate out of range");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker #(
  .FRAME_SIZE (FRAME_SIZE)
) u_mcr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
